// ----- rtl/core/gdt_pkg.sv -----
// Shared types and constants of the graph degree table.
// Used by the controller, the datapath and the top level; no dependencies.
package gdt_pkg;

    localparam int NODE_COUNT_DEF = 64;
    localparam int ACTION_W       = 2;
    localparam int NODE_W         = 6;
    localparam int DEG_W          = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD = 2'd0,
        ACT_REM = 2'd1,
        ACT_CMP = 2'd2,
        ACT_MIN = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_START,
        OP_ADD_RA,
        OP_ADD_UA,
        OP_ADD_RB,
        OP_ADD_UB,
        OP_REM_CHK,
        OP_LST_RD,
        OP_LST_DEG,
        OP_PACK,
        OP_REM_RR,
        OP_REM_LR,
        OP_REM_SCAN,
        OP_REM_FIX,
        OP_REM_CLR,
        OP_CMP_CHK,
        OP_MIN_CHK,
        OP_CNT_CHK,
        OP_SEL_CHK,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        action_t in_action;
        logic    ab_in_range;
        logic    a_in_range;
        logic    edge_hit;
        logic    self_loop;
        logic    a_listed;
        logic    count_zero;
        logic    idx_last;
        logic    scan_last;
        logic    scan_hit;
        logic    deg_match;
        logic    last_pending;
        logic    out_free;
    } status_t;

endpackage

// ----- rtl/core/gdt_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module gdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/gdt_ctrl.sv -----
// Sequencing state machine of the graph degree table.
// Depends on gdt_pkg; drives datapath commands from datapath status.
module gdt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output gdt_pkg::cmd_t     cmd,
    input  gdt_pkg::status_t  status
);

    import gdt_pkg::*;

    typedef enum logic [18:0] {
        ST_IDLE     = 19'h00001,
        ST_ADD_RA   = 19'h00002,
        ST_ADD_UA   = 19'h00004,
        ST_ADD_RB   = 19'h00008,
        ST_ADD_UB   = 19'h00010,
        ST_REM_CHK  = 19'h00020,
        ST_L_RD     = 19'h00040,
        ST_L_DEG    = 19'h00080,
        ST_PACK     = 19'h00100,
        ST_REM_RR   = 19'h00200,
        ST_REM_LR   = 19'h00400,
        ST_REM_SCAN = 19'h00800,
        ST_REM_FIX  = 19'h01000,
        ST_REM_CLR  = 19'h02000,
        ST_CMP_CHK  = 19'h04000,
        ST_MIN_CHK  = 19'h08000,
        ST_CNT_CHK  = 19'h10000,
        ST_SEL_CHK  = 19'h20000,
        ST_EMIT     = 19'h40000
    } state_t;

    typedef enum logic [2:0] {
        PASS_PACK,
        PASS_CMP,
        PASS_MIN,
        PASS_CNT,
        PASS_SEL
    } pass_t;

    state_t state_reg, state_next;
    pass_t  pass_reg, pass_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pass_reg  <= PASS_PACK;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd.op     = OP_IDLE;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_START;
                    case (status.in_action)
                        ACT_ADD: state_next = ST_ADD_RA;
                        ACT_REM: state_next = ST_REM_CHK;
                        ACT_CMP: begin
                            pass_next  = PASS_CMP;
                            state_next = status.count_zero ? ST_EMIT : ST_L_RD;
                        end
                        ACT_MIN: begin
                            pass_next  = PASS_MIN;
                            state_next = status.count_zero ? ST_EMIT : ST_L_RD;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_RA: begin
                cmd.op     = OP_ADD_RA;
                state_next = status.ab_in_range ? ST_ADD_UA : ST_EMIT;
            end
            ST_ADD_UA: begin
                cmd.op     = OP_ADD_UA;
                state_next = (status.edge_hit || status.self_loop) ? ST_EMIT : ST_ADD_RB;
            end
            ST_ADD_RB: begin
                cmd.op     = OP_ADD_RB;
                state_next = ST_ADD_UB;
            end
            ST_ADD_UB: begin
                cmd.op     = OP_ADD_UB;
                state_next = ST_EMIT;
            end
            ST_REM_CHK: begin
                cmd.op = OP_REM_CHK;
                if (!status.a_in_range) begin
                    state_next = ST_EMIT;
                end else if (status.a_listed) begin
                    pass_next  = PASS_PACK;
                    state_next = ST_L_RD;
                end else begin
                    state_next = ST_REM_RR;
                end
            end
            ST_L_RD: begin
                cmd.op     = OP_LST_RD;
                state_next = (pass_reg == PASS_PACK) ? ST_PACK : ST_L_DEG;
            end
            ST_L_DEG: begin
                cmd.op = OP_LST_DEG;
                case (pass_reg)
                    PASS_CMP: state_next = ST_CMP_CHK;
                    PASS_MIN: state_next = ST_MIN_CHK;
                    PASS_CNT: state_next = ST_CNT_CHK;
                    default:  state_next = ST_SEL_CHK;
                endcase
            end
            ST_PACK: begin
                cmd.op     = OP_PACK;
                state_next = status.idx_last ? ST_REM_RR : ST_L_RD;
            end
            ST_REM_RR: begin
                cmd.op     = OP_REM_RR;
                state_next = ST_REM_LR;
            end
            ST_REM_LR: begin
                cmd.op     = OP_REM_LR;
                state_next = ST_REM_SCAN;
            end
            ST_REM_SCAN: begin
                cmd.op = OP_REM_SCAN;
                if (status.scan_hit) begin
                    state_next = ST_REM_FIX;
                end else if (status.scan_last) begin
                    state_next = ST_REM_CLR;
                end
            end
            ST_REM_FIX: begin
                cmd.op     = OP_REM_FIX;
                state_next = status.scan_last ? ST_REM_CLR : ST_REM_SCAN;
            end
            ST_REM_CLR: begin
                cmd.op     = OP_REM_CLR;
                state_next = ST_EMIT;
            end
            ST_CMP_CHK: begin
                cmd.op     = OP_CMP_CHK;
                state_next = status.idx_last ? ST_EMIT : ST_L_RD;
            end
            ST_MIN_CHK: begin
                cmd.op     = OP_MIN_CHK;
                state_next = ST_L_RD;
                if (status.idx_last) begin
                    pass_next = PASS_CNT;
                end
            end
            ST_CNT_CHK: begin
                cmd.op     = OP_CNT_CHK;
                state_next = ST_L_RD;
                if (status.idx_last) begin
                    pass_next = PASS_SEL;
                end
            end
            ST_SEL_CHK: begin
                cmd.op = OP_SEL_CHK;
                if (status.deg_match) begin
                    state_next = ST_EMIT;
                end else if (status.idx_last) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_L_RD;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = status.last_pending ? ST_IDLE : ST_L_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/gdt_datapath.sv -----
// Datapath of the graph degree table: adjacency, degree and list RAMs,
// scan counters and the result register. Depends on gdt_pkg and gdt_ram.
module gdt_datapath #(
    parameter int NODE_COUNT = gdt_pkg::NODE_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gdt_pkg::cmd_t                 cmd,
    output gdt_pkg::status_t              status,
    input  logic [gdt_pkg::ACTION_W-1:0]  s_action,
    input  logic [gdt_pkg::NODE_W-1:0]    s_node_a,
    input  logic [gdt_pkg::NODE_W-1:0]    s_node_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gdt_pkg::NODE_W-1:0]    m_node_id,
    output logic [gdt_pkg::DEG_W-1:0]     m_degree_value,
    output logic                          m_flag,
    output logic                          m_empty_res,
    output logic                          m_last
);

    import gdt_pkg::*;

    localparam int NW = $clog2(NODE_COUNT);
    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(NODE_COUNT);
    localparam logic [CW-1:0] IDX_END   = CW'(NODE_COUNT - 1);
    localparam logic [NODE_COUNT-1:0] BIT0 = NODE_COUNT'(1);

    logic [ACTION_W-1:0]   act_reg, act_next;
    logic [NODE_W-1:0]     a_reg, a_next, b_reg, b_next;
    logic [CW-1:0]         idx_reg, idx_next, wr_reg, wr_next;
    logic [CW-1:0]         count_reg, count_next, cnt_reg, cnt_next;
    logic [CW-1:0]         total_reg, total_next;
    logic [CW-1:0]         acc_reg, acc_next, res_deg_reg, res_deg_next;
    logic [NODE_COUNT-1:0] listed_reg, listed_next, rowv_reg, rowv_next;
    logic [NODE_COUNT-1:0] degv_reg, degv_next, row_reg, row_next;
    logic [NW-1:0]         node_reg, node_next;
    logic [NW-1:0]         adj_ra_reg, deg_ra_reg;
    logic                  flag_reg, flag_next, empty_reg, empty_next;
    logic                  last_reg, last_next;
    logic                  m_valid_reg, m_valid_next;
    logic [NODE_W-1:0]     m_node_reg;
    logic [DEG_W-1:0]      m_deg_reg;
    logic                  m_flag_reg, m_empty_reg, m_last_reg;

    logic                  adj_we, deg_we, lst_we;
    logic [NW-1:0]         adj_wa, adj_ra, deg_wa, deg_ra, lst_wa, lst_ra;
    logic [NODE_COUNT-1:0] adj_wd, adj_rd, row_q;
    logic [CW-1:0]         deg_wd, deg_rd, deg_q, deg_inc, idx_adv;
    logic [NW-1:0]         lst_wd, lst_rd, a_n, b_n, idx_n, bump_node;
    logic                  bump_en, keep;

    gdt_ram #(.WIDTH(NODE_COUNT), .DEPTH(NODE_COUNT)) u_adj_ram (
        .clk(aclk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
        .raddr(adj_ra), .rdata(adj_rd)
    );

    gdt_ram #(.WIDTH(CW), .DEPTH(NODE_COUNT)) u_deg_ram (
        .clk(aclk), .we(deg_we), .waddr(deg_wa), .wdata(deg_wd),
        .raddr(deg_ra), .rdata(deg_rd)
    );

    gdt_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_lst_ram (
        .clk(aclk), .we(lst_we), .waddr(lst_wa), .wdata(lst_wd),
        .raddr(lst_ra), .rdata(lst_rd)
    );

    assign a_n     = NW'(a_reg);
    assign b_n     = NW'(b_reg);
    assign idx_n   = idx_reg[NW-1:0];
    assign row_q   = rowv_reg[adj_ra_reg] ? adj_rd : '0;
    assign deg_q   = degv_reg[deg_ra_reg] ? deg_rd : '0;
    assign deg_inc = deg_q + CW'(1);
    assign idx_adv = status.idx_last ? '0 : idx_reg + CW'(1);
    assign keep    = (lst_rd != a_n);

    always_comb begin
        adj_ra = a_n;
        deg_ra = a_n;
        case (cmd.op)
            OP_ADD_RB:   begin adj_ra = b_n;   deg_ra = b_n;   end
            OP_REM_SCAN: begin adj_ra = idx_n; deg_ra = idx_n; end
            OP_LST_DEG:  deg_ra = lst_rd;
            default: ;
        endcase
    end
    assign lst_ra = idx_n;

    assign status.in_action    = action_t'(s_action);
    assign status.a_in_range   = 32'(a_reg) < 32'(NODE_COUNT);
    assign status.ab_in_range  = status.a_in_range && (32'(b_reg) < 32'(NODE_COUNT));
    assign status.edge_hit     = row_q[b_n];
    assign status.self_loop    = (a_reg == b_reg);
    assign status.a_listed     = listed_reg[a_n];
    assign status.count_zero   = (count_reg == '0);
    assign status.idx_last     = (idx_reg + CW'(1)) == count_reg;
    assign status.scan_last    = (idx_reg == IDX_END);
    assign status.scan_hit     = row_reg[idx_n] && (idx_n != a_n);
    assign status.deg_match    = (deg_q == acc_reg);
    assign status.last_pending = last_reg;
    assign status.out_free     = !m_valid_reg || m_ready;

    always_comb begin
        act_next     = act_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        idx_next     = idx_reg;
        wr_next      = wr_reg;
        count_next   = count_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        acc_next     = acc_reg;
        res_deg_next = res_deg_reg;
        listed_next  = listed_reg;
        rowv_next    = rowv_reg;
        degv_next    = degv_reg;
        row_next     = row_reg;
        node_next    = node_reg;
        flag_next    = flag_reg;
        empty_next   = empty_reg;
        last_next    = last_reg;
        adj_we       = 1'b0;
        adj_wa       = a_n;
        adj_wd       = row_q | (BIT0 << b_n);
        deg_we       = 1'b0;
        deg_wa       = a_n;
        deg_wd       = deg_inc;
        lst_we       = 1'b0;
        lst_wa       = count_reg[NW-1:0];
        bump_node    = (cmd.op == OP_ADD_UB) ? b_n : a_n;
        lst_wd       = bump_node;
        bump_en      = 1'b0;
        case (cmd.op)
            OP_START: begin
                act_next     = s_action;
                a_next       = s_node_a;
                b_next       = s_node_b;
                idx_next     = '0;
                wr_next      = '0;
                cnt_next     = '0;
                total_next   = '0;
                acc_next     = '1;
                res_deg_next = '0;
                node_next    = '0;
                flag_next    = (action_t'(s_action) == ACT_CMP);
                empty_next   = (action_t'(s_action) == ACT_MIN) && (count_reg == '0);
                last_next    = 1'b1;
            end
            OP_ADD_UA: begin
                res_deg_next = status.edge_hit ? deg_q : deg_inc;
                if (!status.edge_hit) begin
                    adj_we          = 1'b1;
                    deg_we          = 1'b1;
                    rowv_next[a_n]  = 1'b1;
                    degv_next[a_n]  = 1'b1;
                    flag_next       = 1'b1;
                    bump_en         = 1'b1;
                end
            end
            OP_ADD_UB: begin
                adj_we         = 1'b1;
                adj_wa         = b_n;
                adj_wd         = row_q | (BIT0 << a_n);
                deg_we         = 1'b1;
                deg_wa         = b_n;
                rowv_next[b_n] = 1'b1;
                degv_next[b_n] = 1'b1;
                bump_en        = 1'b1;
            end
            OP_REM_CHK: flag_next = status.a_in_range && listed_reg[a_n];
            OP_LST_DEG: node_next = lst_rd;
            OP_PACK: begin
                if (keep) begin
                    lst_we  = 1'b1;
                    lst_wa  = wr_reg[NW-1:0];
                    lst_wd  = lst_rd;
                    wr_next = wr_reg + CW'(1);
                end
                idx_next = idx_adv;
                if (status.idx_last) begin
                    count_next       = wr_reg + CW'(keep);
                    listed_next[a_n] = 1'b0;
                end
            end
            OP_REM_RR: idx_next = '0;
            OP_REM_LR: row_next = row_q;
            OP_REM_SCAN: begin
                if (!status.scan_hit && !status.scan_last) begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            OP_REM_FIX: begin
                adj_we           = 1'b1;
                adj_wa           = idx_n;
                adj_wd           = row_q & ~(BIT0 << a_n);
                deg_we           = 1'b1;
                deg_wa           = idx_n;
                deg_wd           = (deg_q == '0) ? '0 : deg_q - CW'(1);
                rowv_next[idx_n] = 1'b1;
                degv_next[idx_n] = 1'b1;
                if (!status.scan_last) begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            OP_REM_CLR: begin
                adj_we         = 1'b1;
                adj_wd         = '0;
                deg_we         = 1'b1;
                deg_wd         = '0;
                rowv_next[a_n] = 1'b1;
                degv_next[a_n] = 1'b1;
            end
            OP_CMP_CHK: begin
                if (deg_inc != count_reg) begin
                    flag_next = 1'b0;
                end
                idx_next = idx_adv;
            end
            OP_MIN_CHK: begin
                if (deg_q < acc_reg) begin
                    acc_next = deg_q;
                end
                idx_next = idx_adv;
            end
            OP_CNT_CHK: begin
                if (status.deg_match) begin
                    total_next = total_reg + CW'(1);
                end
                idx_next = idx_adv;
            end
            OP_SEL_CHK: begin
                if (status.deg_match) begin
                    cnt_next  = cnt_reg + CW'(1);
                    last_next = (cnt_reg + CW'(1)) == total_reg;
                end
                idx_next = idx_reg + CW'(1);
            end
            default: ;
        endcase
        // node joins the list when its degree first becomes nonzero
        if (bump_en && deg_inc == CW'(1) && !listed_reg[bump_node]
                && count_reg < COUNT_MAX) begin
            lst_we                 = 1'b1;
            count_next             = count_reg + CW'(1);
            listed_next[bump_node] = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.op == OP_EMIT) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            listed_reg  <= '0;
            rowv_reg    <= '0;
            degv_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            listed_reg  <= listed_next;
            rowv_reg    <= rowv_next;
            degv_reg    <= degv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        idx_reg     <= idx_next;
        wr_reg      <= wr_next;
        cnt_reg     <= cnt_next;
        total_reg   <= total_next;
        acc_reg     <= acc_next;
        res_deg_reg <= res_deg_next;
        row_reg     <= row_next;
        node_reg    <= node_next;
        flag_reg    <= flag_next;
        empty_reg   <= empty_next;
        last_reg    <= last_next;
        adj_ra_reg  <= adj_ra;
        deg_ra_reg  <= deg_ra;
        if (cmd.op == OP_EMIT) begin
            m_node_reg  <= (action_t'(act_reg) == ACT_MIN) ? NODE_W'(node_reg) : a_reg;
            m_deg_reg   <= empty_reg ? '0 :
                           (action_t'(act_reg) == ACT_MIN) ? DEG_W'(acc_reg)
                                                           : DEG_W'(res_deg_reg);
            m_flag_reg  <= flag_reg;
            m_empty_reg <= empty_reg;
            m_last_reg  <= last_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_node_id      = m_node_reg;
    assign m_degree_value = m_deg_reg;
    assign m_flag         = m_flag_reg;
    assign m_empty_res    = m_empty_reg;
    assign m_last         = m_last_reg;

endmodule

// ----- rtl/core/graph_degree_table_unit.sv -----
// Graph degree table: undirected graph of NODE_COUNT nodes held as an
// adjacency RAM with a degree RAM and an ordered list of active nodes. One
// request is worked at a time, each step a single RAM access. Remove node
// packs the list when the node is listed, then scans the adjacency row and
// fixes each neighbor; the complete-graph query walks the list once, and the
// minimum degree query makes three list passes. Each result is held in an
// output register.
module graph_degree_table_unit #(
    parameter int NODE_COUNT = gdt_pkg::NODE_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gdt_pkg::ACTION_W-1:0]  s_action,
    input  logic [gdt_pkg::NODE_W-1:0]    s_node_a,
    input  logic [gdt_pkg::NODE_W-1:0]    s_node_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gdt_pkg::NODE_W-1:0]    m_node_id,
    output logic [gdt_pkg::DEG_W-1:0]     m_degree_value,
    output logic                          m_flag,
    output logic                          m_empty_res,
    output logic                          m_last
);

    import gdt_pkg::*;

    cmd_t    cmd;
    status_t status;

    gdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    gdt_datapath #(.NODE_COUNT(NODE_COUNT)) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_action       (s_action),
        .s_node_a       (s_node_a),
        .s_node_b       (s_node_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_node_id      (m_node_id),
        .m_degree_value (m_degree_value),
        .m_flag         (m_flag),
        .m_empty_res    (m_empty_res),
        .m_last         (m_last)
    );

endmodule

// ----- rtl/core/gdt_chk.sv -----
// Port-level checker for graph_degree_table_unit, bound to the top level.
// Depends on gdt_pkg for field widths.
module gdt_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [gdt_pkg::ACTION_W-1:0]  s_action,
    input logic [gdt_pkg::NODE_W-1:0]    s_node_a,
    input logic [gdt_pkg::NODE_W-1:0]    s_node_b,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [gdt_pkg::NODE_W-1:0]    m_node_id,
    input logic [gdt_pkg::DEG_W-1:0]     m_degree_value,
    input logic                          m_flag,
    input logic                          m_empty_res,
    input logic                          m_last
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_node_id)
            && $stable(m_degree_value) && $stable(m_last))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_action)
            && $stable(s_node_a) && $stable(s_node_b))
        else $error("waiting request changed");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> m_last && !m_flag
            && m_node_id == '0 && m_degree_value == '0)
        else $error("malformed empty result");

endmodule

bind graph_degree_table_unit gdt_chk u_gdt_chk (.*);

// ----- tb/graph_degree_table_unit_test.sv -----
// Self-checking bench for graph_degree_table_unit: directed then random requests
// checked against a behavioral graph model. Depends on gdt_pkg and the DUT.
module graph_degree_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gdt_pkg::*;

    localparam int NN = NODE_COUNT_DEF;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [NODE_W-1:0]   a;
        logic [NODE_W-1:0]   b;
    } request_t;

    typedef struct packed {
        logic [NODE_W-1:0] id;
        logic [DEG_W-1:0]  deg;
        logic              flag;
        logic              empty;
        logic              last;
    } answer_t;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, m_ready = 0;
    logic [ACTION_W-1:0] s_action = '0;
    logic [NODE_W-1:0] s_node_a = '0, s_node_b = '0;
    logic s_ready, m_valid, m_flag, m_empty_res, m_last;
    logic [NODE_W-1:0] m_node_id;
    logic [DEG_W-1:0] m_degree_value;

    graph_degree_table_unit #(.NODE_COUNT(NN)) DUT (.*);

    initial forever #4 aclk = ~aclk;

    request_t pending_q[$];
    answer_t  answer_q[$];
    int errors = 0;
    int cycles = 0;
    bit stim_done = 0;

    // graph shadow
    logic [NN-1:0] adj[NN];
    int deg[NN];
    int order[$];
    bit listed[NN];

    function automatic void post_answer(answer_t o);
        answer_q.insert(answer_q.size(), o);
    endfunction

    function automatic void enlist(int n);
        order.insert(order.size(), n);
        listed[n] = 1'b1;
    endfunction

    function automatic void add_req(request_t r);
        pending_q.insert(pending_q.size(), r);
    endfunction

    function automatic void model_request(request_t r);
        answer_t o;
        int m, tot, cnt;
        bit full;
        o = '0;
        o.last = 1'b1;
        o.id = r.a;
        case (action_t'(r.action))
            ACT_ADD: begin
                if (!adj[r.a][r.b]) begin
                    o.flag = 1'b1;
                    adj[r.a][r.b] = 1'b1;
                    adj[r.b][r.a] = 1'b1;
                    deg[r.a]++;
                    if (deg[r.a] == 1 && !listed[r.a]) enlist(int'(r.a));
                    if (r.b != r.a) begin
                        deg[r.b]++;
                        if (deg[r.b] == 1 && !listed[r.b]) enlist(int'(r.b));
                    end
                end
                o.deg = DEG_W'(deg[r.a]);
                post_answer(o);
            end
            ACT_REM: begin
                if (listed[r.a]) begin
                    o.flag = 1'b1;
                    for (int i = order.size() - 1; i >= 0; i--)
                        if (order[i] == r.a) order.delete(i);
                    listed[r.a] = 1'b0;
                end
                for (int j = 0; j < NN; j++)
                    if (j != r.a && adj[r.a][j]) begin
                        adj[j][r.a] = 1'b0;
                        if (deg[j] > 0) deg[j]--;
                    end
                adj[r.a] = '0;
                deg[r.a] = 0;
                post_answer(o);
            end
            ACT_CMP: begin
                full = 1'b1;
                foreach (order[i]) if (deg[order[i]] + 1 != order.size()) full = 1'b0;
                o.flag = full;
                post_answer(o);
            end
            default: begin
                if (order.size() == 0) begin
                    o.id = '0; o.empty = 1'b1;
                    post_answer(o);
                end else begin
                    m = 1 << 20; tot = 0; cnt = 0;
                    foreach (order[i]) if (deg[order[i]] < m) m = deg[order[i]];
                    foreach (order[i]) if (deg[order[i]] == m) tot++;
                    foreach (order[i]) if (deg[order[i]] == m) begin
                        cnt++;
                        o.id = NODE_W'(order[i]); o.deg = DEG_W'(m); o.flag = 1'b0;
                        o.last = (cnt == tot);
                        post_answer(o);
                    end
                end
            end
        endcase
    endfunction

    // sender: bursts and gaps
    int burst = 0, gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                model_request(pending_q.pop_front());
            end
            if (!s_valid || s_ready) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    s_valid <= 0;
                end else if (pending_q.size() > 0) begin
                    s_valid <= 1;
                    s_action <= pending_q[0].action;
                    s_node_a <= pending_q[0].a;
                    s_node_b <= pending_q[0].b;
                    if (burst == 0) begin
                        burst <= $urandom_range(1, 12);
                        gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end else burst <= burst - 1;
                end else s_valid <= 0;
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    int hold = 0;
    bit held = 0;
    int rx_count = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!held && rx_count >= 120) begin
                held = 1; hold = 3000;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 0;
            end else begin
                case ((cycles / 500) % 3)
                    0: m_ready <= 1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        answer_t e;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            rx_count++;
            if (answer_q.size() == 0) begin
                $error("unexpected result node_id %0d", m_node_id);
                errors++;
            end else begin
                e = answer_q.pop_front();
                if (m_node_id !== e.id) begin
                    $error("node_id exp %0d got %0d", e.id, m_node_id); errors++;
                end
                if (m_degree_value !== e.deg) begin
                    $error("degree_value exp %0d got %0d", e.deg, m_degree_value); errors++;
                end
                if (m_flag !== e.flag) begin
                    $error("flag exp %0d got %0d", e.flag, m_flag); errors++;
                end
                if (m_empty_res !== e.empty) begin
                    $error("empty_res exp %0d got %0d", e.empty, m_empty_res); errors++;
                end
                if (m_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, m_last); errors++;
                end
            end
        end
    end

    function automatic request_t mk(int act, int a, int b);
        request_t r;
        r.action = ACTION_W'(act); r.a = NODE_W'(a); r.b = NODE_W'(b);
        return r;
    endfunction

    initial begin
        int r, hub;
        for (int i = 0; i < NN; i++) begin
            adj[i] = '0; deg[i] = 0; listed[i] = 0;
        end
        add_req(mk(ACT_MIN, 0, 0));
        add_req(mk(ACT_CMP, 5, 0));
        add_req(mk(ACT_ADD, 0, 63));
        add_req(mk(ACT_ADD, 63, 0));
        add_req(mk(ACT_ADD, 7, 7));
        add_req(mk(ACT_ADD, 7, 7));
        add_req(mk(ACT_CMP, 0, 0));
        add_req(mk(ACT_ADD, 0, 7));
        add_req(mk(ACT_ADD, 63, 7));
        add_req(mk(ACT_CMP, 63, 0));
        add_req(mk(ACT_MIN, 0, 0));
        add_req(mk(ACT_REM, 42, 0));
        add_req(mk(ACT_REM, 7, 0));
        add_req(mk(ACT_MIN, 0, 0));
        add_req(mk(ACT_REM, 0, 0));
        add_req(mk(ACT_MIN, 0, 0));
        add_req(mk(ACT_REM, 63, 0));
        add_req(mk(ACT_MIN, 63, 63));
        for (int i = 0; i < 350; i++) begin
            r = $urandom_range(0, 99);
            hub = $urandom_range(0, 15);
            if (r < 50)
                add_req(mk(ACT_ADD,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : hub,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, 15)));
            else if (r < 65)
                add_req(mk(ACT_REM,
                    ($urandom_range(0, 2) == 0) ? $urandom_range(0, 63) : hub,
                    $urandom_range(0, 63)));
            else if (r < 80)
                add_req(mk(ACT_CMP, $urandom_range(0, 63), $urandom_range(0, 63)));
            else
                add_req(mk(ACT_MIN, $urandom_range(0, 63), $urandom_range(0, 63)));
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        while (pending_q.size() > 0 || s_valid) @(posedge aclk);
        while (answer_q.size() > 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        stim_done = 1;
    end

    always @(posedge aclk) begin
        if (stim_done) begin
            if (errors == 0 && answer_q.size() == 0)
                $display("SCOREBOARD CLEAN");
            else
                $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (cycles > 3000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end
endmodule
